// ----- rtl/core/vumlr_pkg.sv -----
// Shared types and constants for the stereo VU meter LED renderer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vumlr_pkg;

    typedef enum logic [1:0] {
        MODE_CLASSIC = 2'd0,
        MODE_FIRE    = 2'd1,
        MODE_OCEAN   = 2'd2,
        MODE_SOLID   = 2'd3
    } mode_t;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL  = 8'd3;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] decay_step;
        logic [7:0] hold_frames;
        logic [3:0] fall_interval;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:          MODE_CLASSIC,
        decay_step:    4'd3,
        hold_frames:   8'd48,
        fall_interval: 4'd2
    };

endpackage

`default_nettype wire

// ----- rtl/core/vumlr_if.sv -----
// Handshake interfaces: level input, LED color output, register writes.
// Depends on vumlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vumlr_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] left_vol;
    logic [4:0] right_vol;

    modport source (output valid, output left_vol, output right_vol, input ready);
    modport sink   (input valid, input left_vol, input right_vol, output ready);
endinterface

interface vumlr_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output led_index, output red, output green, output blue,
                    output last, input ready);
    modport sink   (input valid, input led_index, input red, input green, input blue,
                    input last, output ready);
endinterface

interface vumlr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vumlr_pkg::CFG_IDX_W-1:0]  index;
    logic [vumlr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/vumlr_cfg.sv -----
// Configuration register file: mode, decay step, hold frames, fall interval.
// Depends on vumlr_pkg and vumlr_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module vumlr_cfg
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    vumlr_cfg_if.sink      wr,
    output vumlr_pkg::cfg_t cfg
);
    import vumlr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr.ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr.valid)
        begin
            case (wr.index)
                REG_MODE:  cfg_next.mode          = mode_t'(wr.data[1:0]);
                REG_DECAY: cfg_next.decay_step    = wr.data[3:0];
                REG_HOLD:  cfg_next.hold_frames   = wr.data[7:0];
                REG_FALL:  cfg_next.fall_interval = wr.data[3:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/vumlr_track.sv -----
// Per-channel level tracking: display level decay, bar height, peak hold and fall.
// Depends on vumlr_pkg and vumlr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module vumlr_track
#(
    parameter int BAR_LEDS = 16,
    parameter int HW       = $clog2(BAR_LEDS + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    vumlr_in_if.sink             levels,
    input  vumlr_pkg::cfg_t      cfg,
    input  wire logic            take,
    output logic                 pending,
    output logic [1:0][HW-1:0]   heights,
    output logic [1:0][HW-1:0]   peaks
);
    import vumlr_pkg::*;

    localparam int DW = $clog2(BAR_LEDS * 10 + 1);
    localparam int MW = DW + 8;

    logic [1:0][DW-1:0] disp_reg,   disp_next;
    logic [1:0][HW-1:0] height_reg, height_next;
    logic [1:0][HW-1:0] peak_reg,   peak_next;
    logic [1:0][7:0]    hold_reg,   hold_next;
    logic [1:0][3:0]    fall_reg,   fall_next;
    logic               pending_reg, pending_next;
    logic               accept;

    logic [1:0][4:0]    raw;
    logic [1:0][HW-1:0] lvl;
    logic [1:0][DW-1:0] target;
    logic [1:0][DW-1:0] disp_upd;
    logic [1:0][MW-1:0] prod;
    logic [1:0][HW-1:0] h_upd;
    logic [1:0][3:0]    fall_inc;

    assign levels.ready = !pending_reg;
    assign accept       = levels.valid && !pending_reg;
    assign pending      = pending_reg;
    assign heights      = height_reg;
    assign peaks        = peak_reg;
    assign raw[0]       = levels.left_vol;
    assign raw[1]       = levels.right_vol;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (8'(raw[c]) > 8'(BAR_LEDS))
                lvl[c] = HW'(BAR_LEDS);
            else
                lvl[c] = HW'(raw[c]);
            target[c] = DW'(DW'(lvl[c]) * DW'(10));

            if (target[c] > disp_reg[c])
                disp_upd[c] = target[c];
            else if (disp_reg[c] >= DW'(cfg.decay_step))
                disp_upd[c] = disp_reg[c] - DW'(cfg.decay_step);
            else
                disp_upd[c] = '0;

            // divide by ten: x * 205 >> 11 is exact below 1029
            prod[c]  = MW'(disp_upd[c]) * MW'(205);
            h_upd[c] = HW'(prod[c] >> 11);

            fall_inc[c] = fall_reg[c] + 4'd1;
        end
    end

    always_comb
    begin
        disp_next    = disp_reg;
        height_next  = height_reg;
        peak_next    = peak_reg;
        hold_next    = hold_reg;
        fall_next    = fall_reg;
        pending_next = pending_reg;

        if (take)
            pending_next = 1'b0;

        if (accept)
        begin
            pending_next = 1'b1;
            for (int c = 0; c < 2; c++)
            begin
                disp_next[c]   = disp_upd[c];
                height_next[c] = h_upd[c];
                if (h_upd[c] >= peak_reg[c])
                begin
                    peak_next[c] = h_upd[c];
                    hold_next[c] = cfg.hold_frames;
                    fall_next[c] = '0;
                end
                else if (hold_reg[c] != 8'd0)
                begin
                    hold_next[c] = hold_reg[c] - 8'd1;
                end
                else if (peak_reg[c] != '0)
                begin
                    if (fall_inc[c] >= cfg.fall_interval)
                    begin
                        peak_next[c] = peak_reg[c] - HW'(1);
                        fall_next[c] = '0;
                    end
                    else
                    begin
                        fall_next[c] = fall_inc[c];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg    <= '0;
            height_reg  <= '0;
            peak_reg    <= '0;
            hold_reg    <= '0;
            fall_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            disp_reg    <= disp_next;
            height_reg  <= height_next;
            peak_reg    <= peak_next;
            hold_reg    <= hold_next;
            fall_reg    <= fall_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/vumlr_render.sv -----
// Frame renderer: walks both bars into an output register, one LED per cycle unless leds stalls.
// Depends on vumlr_pkg and vumlr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module vumlr_render
#(
    parameter int BAR_LEDS = 16,
    parameter int HW       = $clog2(BAR_LEDS + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  vumlr_pkg::cfg_t      cfg,
    input  wire logic            pending,
    output logic                 take,
    input  wire logic [1:0][HW-1:0] heights,
    input  wire logic [1:0][HW-1:0] peaks,
    vumlr_out_if.source          leds
);
    import vumlr_pkg::*;

    localparam int PW = $clog2(BAR_LEDS);
    localparam int IW = $clog2(2 * BAR_LEDS);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    function automatic rgb_t led_rgb(input mode_t m, input logic ch, input logic [7:0] i,
                                     input logic lit, input logic peak_here);
        rgb_t       c;
        logic [7:0] heat;
        c    = '0;
        heat = {i[3:0], 4'b0000};
        if (lit)
        begin
            case (m)
                MODE_CLASSIC:
                begin
                    if (i < 8'd10)
                    begin
                        c.r = 8'(i * 8'd25);
                        c.g = 8'd220;
                    end
                    else if (i < 8'd14)
                    begin
                        c.r = 8'd255;
                        c.g = 8'(8'd220 - 8'((i - 8'd10) * 8'd55));
                    end
                    else
                    begin
                        c.r = 8'd255;
                    end
                end
                MODE_FIRE:
                begin
                    c.r = 8'd255;
                    c.g = heat;
                    c.b = (heat > 8'd128) ? heat - 8'd128 : 8'd0;
                end
                MODE_OCEAN:
                begin
                    c.g = 8'(i * 8'd15);
                    c.b = 8'(8'd100 + 8'(i * 8'd9));
                end
                MODE_SOLID:
                begin
                    if (!ch)
                    begin
                        c.r = 8'd180;
                        c.b = 8'd255;
                    end
                    else
                    begin
                        c.g = 8'd220;
                        c.b = 8'd255;
                    end
                end
                default: c = '0;
            endcase
        end
        if (peak_here)
        begin
            case (m)
                MODE_CLASSIC: c = '{r: 8'd255, g: 8'd255, b: 8'd255};
                MODE_FIRE:    c = '{r: 8'd255, g: 8'd255, b: 8'd200};
                MODE_OCEAN:   c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
                default:      c = c;
            endcase
        end
        return c;
    endfunction

    logic [1:0][HW-1:0] frame_h_reg, frame_p_reg;
    logic               active_reg;
    logic [PW-1:0]      pos_reg;
    logic               ch_reg;
    logic [IW-1:0]      idx_reg;
    logic               valid_reg;
    logic [4:0]         index_reg;
    rgb_t               rgb_reg;
    logic               last_reg;

    logic               advance;
    logic               last_led;
    logic [HW-1:0]      cur_h, cur_p, pos_ext;
    logic               lit, peak_here;
    rgb_t               rgb;

    assign advance  = active_reg && (!valid_reg || leds.ready);
    assign last_led = ch_reg && (pos_reg == PW'(BAR_LEDS - 1));
    assign take     = pending && (!active_reg || (advance && last_led));

    assign cur_h     = ch_reg ? frame_h_reg[1] : frame_h_reg[0];
    assign cur_p     = ch_reg ? frame_p_reg[1] : frame_p_reg[0];
    assign pos_ext   = HW'(pos_reg);
    assign lit       = pos_ext < cur_h;
    assign peak_here = (cur_p != '0) && (pos_ext + HW'(1) == cur_p);
    assign rgb       = led_rgb(cfg.mode, ch_reg, 8'(pos_reg), lit, peak_here);

    assign leds.valid     = valid_reg;
    assign leds.led_index = index_reg;
    assign leds.red       = rgb_reg.r;
    assign leds.green     = rgb_reg.g;
    assign leds.blue      = rgb_reg.b;
    assign leds.last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            ch_reg     <= 1'b0;
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_reg <= 1'b1;
                pos_reg    <= '0;
                ch_reg     <= 1'b0;
                idx_reg    <= '0;
            end
            else if (advance)
            begin
                if (last_led)
                    active_reg <= 1'b0;
                else if (pos_reg == PW'(BAR_LEDS - 1))
                begin
                    pos_reg <= '0;
                    ch_reg  <= 1'b1;
                end
                else
                    pos_reg <= pos_reg + PW'(1);
                idx_reg <= idx_reg + IW'(1);
            end

            if (advance)
                valid_reg <= 1'b1;
            else if (leds.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            frame_h_reg <= heights;
            frame_p_reg <= peaks;
        end
        if (advance)
        begin
            index_reg <= 5'(idx_reg);
            rgb_reg   <= rgb;
            last_reg  <= last_led;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stereo_vu_meter_led_renderer.sv -----
// Top level of the stereo VU meter LED renderer.
// Depends on vumlr_pkg, vumlr_if, vumlr_cfg, vumlr_track and vumlr_render.
//
//   Channel  Dir  Payload                                   Transaction
//   levels   in   left_vol, right_vol                       one audio frame
//   leds     out  led_index, red, green, blue, last         one LED color
//   cfg      in   index, data                               one register write
//
// A frame is tracked in the cycle it is accepted, then emits 2*BAR_LEDS colors,
// one per cycle while leds is not stalled, from the output register.
// One further frame is taken while the current one is emitting.
// Reset clears the channel valid and control state (not the LED data registers) and loads the register defaults.
// A stalled leds channel holds the render counters; levels backs up behind it.
`timescale 1ns / 1ps
`default_nettype none

module stereo_vu_meter_led_renderer
#(
    parameter int BAR_LEDS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vumlr_in_if.sink    levels,
    vumlr_out_if.source leds,
    vumlr_cfg_if.sink   cfg
);
    import vumlr_pkg::*;

    localparam int HW = $clog2(BAR_LEDS + 1);

    cfg_t               cfg_val;
    logic               take;
    logic               pending;
    logic [1:0][HW-1:0] heights;
    logic [1:0][HW-1:0] peaks;

    vumlr_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg),
        .cfg   (cfg_val)
    );

    vumlr_track #(.BAR_LEDS(BAR_LEDS), .HW(HW)) u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .levels  (levels),
        .cfg     (cfg_val),
        .take    (take),
        .pending (pending),
        .heights (heights),
        .peaks   (peaks)
    );

    vumlr_render #(.BAR_LEDS(BAR_LEDS), .HW(HW)) u_render
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_val),
        .pending (pending),
        .take    (take),
        .heights (heights),
        .peaks   (peaks),
        .leds    (leds)
    );

endmodule

`default_nettype wire
